// File: hdl/text_console_writer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the text console writer
// Implication checks, sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication
`define TCW_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console writer: check failed");

// Next-cycle implication
`define TCW_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console writer: check failed");

`endif

// File: hdl/tcw_pkg.sv
// ---------------------------------------------------------------------------
// Text console writer package
// Field widths, character codes, state and command types shared by the block.
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int HIST_OUT_W = 7;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [CELL_W-1:0] CELL_RESET = 16'h0F20;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_CLEAR,
    SW_SCROLL
  } sweep_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic   take_in;
    logic   put;
    logic   clr_state;
    logic   rd_cell;
    logic   sweep_on;
    sweep_t sweep_kind;
    logic   load_out;
  } tcw_cmd_t;

  typedef struct packed {
    op_t  op;
    logic need_scroll;
    logic sweep_done;
    logic out_free;
  } tcw_sts_t;

endpackage

// File: hdl/tcw_ctrl.sv
// ---------------------------------------------------------------------------
// Text console writer controller
// Sequences input capture, execution, screen sweeps and result hand-off.
// ---------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (sts.sweep_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (sts.op)
          OP_PUT: begin
            if (sts.need_scroll) state_nxt = ST_SCROLL;
            else if (sts.out_free) state_nxt = ST_IDLE;
            else state_nxt = ST_EMIT;
          end
          OP_CLEAR: state_nxt = ST_CLEAR;
          OP_READ:  state_nxt = ST_EMIT;
          default: begin
            if (sts.out_free) state_nxt = ST_IDLE;
            else state_nxt = ST_EMIT;
          end
        endcase
      end
      ST_SCROLL, ST_CLEAR: begin
        if (sts.sweep_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.sweep_kind = SW_INIT;
    in_ready = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep_on = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
      end
      ST_EXEC: begin
        unique case (sts.op)
          OP_PUT: begin
            cmd.put      = 1'b1;
            cmd.load_out = !sts.need_scroll && sts.out_free;
          end
          OP_CLEAR: cmd.clr_state = 1'b1;
          OP_READ:  cmd.rd_cell   = 1'b1;
          default:  cmd.load_out  = sts.out_free;
        endcase
      end
      ST_SCROLL: begin
        cmd.sweep_on   = 1'b1;
        cmd.sweep_kind = SW_SCROLL;
      end
      ST_CLEAR: begin
        cmd.sweep_on   = 1'b1;
        cmd.sweep_kind = SW_CLEAR;
      end
      ST_EMIT: begin
        cmd.load_out = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  `TCW_ASSERT_IMP(a_load_into_free_slot, cmd.load_out, sts.out_free)
  `TCW_ASSERT_NXT(a_accept_goes_exec, in_valid && in_ready, state_r == ST_EXEC)
  `TCW_ASSERT_NXT(a_scroll_follows_wrap,
                  state_r == ST_EXEC && sts.op == OP_PUT && sts.need_scroll,
                  state_r == ST_SCROLL)

endmodule

// File: hdl/tcw_dpath.sv
// ---------------------------------------------------------------------------
// Text console writer datapath
// Screen store, cursor, tab phase, scroll count, sweep counter, result word.
// ---------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_dpath #(
  parameter int COLUMNS       = 80,
  parameter int ROWS          = 25,
  parameter int HISTORY_DEPTH = 100,
  parameter int TAB_WIDTH     = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tcw_pkg::OP_W-1:0]        in_operation,
  input  logic [tcw_pkg::CHAR_W-1:0]      in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]       in_cell_index,
  input  logic                            cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcw_pkg::CELL_W-1:0]      out_read_data,
  output logic [tcw_pkg::COL_OUT_W-1:0]   out_cursor_col,
  output logic [tcw_pkg::ROW_OUT_W-1:0]   out_cursor_row,
  output logic                            out_scrolled,
  output logic [tcw_pkg::HIST_OUT_W-1:0]  out_scrollback_lines,
  input  tcw_pkg::tcw_cmd_t               cmd,
  output tcw_pkg::tcw_sts_t               sts
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(CELLS + 1);
  localparam int XW     = (AW > IDX_W) ? AW : IDX_W;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int CX_W   = $clog2(COLUMNS + TAB_WIDTH + 1);
  localparam int LN_W   = $clog2(ROWS + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PH_W   = $clog2(TAB_WIDTH);
  localparam int HW     = $clog2(HISTORY_DEPTH + 1);

  op_t                 op_r;
  logic [CHAR_W-1:0]   ch_r;
  logic [IDX_W-1:0]    idx_r;
  logic [ATTR_W-1:0]   attr_r;
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic [PH_W-1:0]     ph_r;
  logic [HW-1:0]       hist_r;
  logic                scr_r;
  logic [CW-1:0]       cnt_r;
  logic [CELL_W-1:0]   rdata_r;
  logic [CELL_W-1:0]   cells_r [CELLS];
  logic                out_valid_r;

  logic [CX_W-1:0]     col_n;
  logic [LN_W-1:0]     line_n;
  logic [PH_W-1:0]     ph_n;
  logic [COL_W-1:0]    wcol;
  logic [CHAR_W-1:0]   wchar;
  logic                wr_put;
  logic                need_scroll;
  logic [COL_W-1:0]    col_c;
  logic [ROW_W-1:0]    row_c;
  logic [AW-1:0]       put_addr;
  logic                sweep_done;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [CELL_W-1:0]   wdata;
  logic                re;
  logic [AW-1:0]       raddr;
  logic [XW-1:0]       idx_ext;
  logic                idx_ok;
  logic                out_free;

  // Cursor move for one put; phase tracks the column modulo the tab width
  always_comb begin
    col_n  = CX_W'(col_r);
    line_n = LN_W'(row_r);
    ph_n   = ph_r;
    wcol   = col_r;
    wchar  = ch_r;
    wr_put = 1'b0;
    case (ch_r)
      CH_NL: begin
        col_n  = '0;
        line_n = LN_W'(row_r) + 1'b1;
        ph_n   = '0;
      end
      CH_BS: begin
        if (col_r != '0) begin
          col_n  = CX_W'(col_r) - 1'b1;
          wcol   = col_r - 1'b1;
          wchar  = CH_BLANK;
          wr_put = 1'b1;
          ph_n   = (ph_r == '0) ? PH_W'(TAB_WIDTH - 1) : ph_r - 1'b1;
        end
      end
      CH_TAB: begin
        col_n = CX_W'(col_r) + CX_W'(TAB_WIDTH) - CX_W'(ph_r);
        ph_n  = '0;
      end
      default: begin
        wr_put = 1'b1;
        col_n  = CX_W'(col_r) + 1'b1;
        ph_n   = (ph_r == PH_W'(TAB_WIDTH - 1)) ? '0 : ph_r + 1'b1;
      end
    endcase
    if (col_n >= CX_W'(COLUMNS)) begin
      col_n  = '0;
      line_n = LN_W'(row_r) + 1'b1;
      ph_n   = '0;
    end
    need_scroll = (line_n == LN_W'(ROWS));
    col_c       = COL_W'(col_n);
    row_c       = need_scroll ? ROW_W'(ROWS - 1) : ROW_W'(line_n);
  end

  assign put_addr = AW'(row_r * COLUMNS) + AW'(wcol);
  assign idx_ext  = XW'(idx_r);
  assign idx_ok   = (idx_ext < XW'(CELLS));
  assign out_free = !out_valid_r || out_ready;

  assign sweep_done = (cmd.sweep_kind == SW_SCROLL) ? (cnt_r == CW'(CELLS))
                                                    : (cnt_r == CW'(CELLS - 1));

  // Store write port: put, or one cell of a sweep
  always_comb begin
    we    = 1'b0;
    waddr = put_addr;
    wdata = {attr_r, wchar};
    if (cmd.put && wr_put) we = 1'b1;
    if (cmd.sweep_on) begin
      unique case (cmd.sweep_kind)
        SW_INIT: begin
          we    = 1'b1;
          waddr = AW'(cnt_r);
          wdata = CELL_RESET;
        end
        SW_CLEAR: begin
          we    = 1'b1;
          waddr = AW'(cnt_r);
          wdata = {attr_r, CH_BLANK};
        end
        SW_SCROLL: begin
          // write lags the read, taking the registered read data; past the copied rows, blank
          we    = (cnt_r != '0);
          waddr = AW'(cnt_r - 1'b1);
          wdata = (cnt_r <= CW'(COPY_N)) ? rdata_r : {attr_r, CH_BLANK};
        end
        default: we = 1'b0;
      endcase
    end
  end

  // Store read port: cell read, or the row below during a scroll
  always_comb begin
    re    = 1'b0;
    raddr = idx_ext[AW-1:0];
    if (cmd.rd_cell) re = 1'b1;
    if (cmd.sweep_on && cmd.sweep_kind == SW_SCROLL && cnt_r < CW'(COPY_N)) begin
      re    = 1'b1;
      raddr = AW'(cnt_r + CW'(COLUMNS));
    end
  end

  always_ff @(posedge clk) begin
    if (we) cells_r[waddr] <= wdata;
    if (re) rdata_r <= cells_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      op_r  <= op_t'(in_operation);
      ch_r  <= in_char_code;
      idx_r <= in_cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
      col_r  <= '0;
      row_r  <= '0;
      ph_r   <= '0;
      hist_r <= '0;
      scr_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) attr_r <= cfg_wdata;
      if (cmd.take_in) scr_r <= 1'b0;
      if (cmd.put) begin
        col_r <= col_c;
        row_r <= row_c;
        ph_r  <= ph_n;
        scr_r <= need_scroll;
        if (need_scroll && hist_r < HW'(HISTORY_DEPTH)) hist_r <= hist_r + 1'b1;
      end
      if (cmd.clr_state) begin
        col_r  <= '0;
        row_r  <= '0;
        ph_r   <= '0;
        hist_r <= '0;
      end
      if (cmd.sweep_on) cnt_r <= sweep_done ? '0 : cnt_r + 1'b1;
    end
  end

  // Result word; on the fast put path the cursor is taken from its next value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_data        <= (op_r == OP_READ && idx_ok) ? rdata_r : '0;
      out_cursor_col       <= COL_OUT_W'(cmd.put ? col_c : col_r);
      out_cursor_row       <= ROW_OUT_W'(cmd.put ? row_c : row_r);
      out_scrolled         <= cmd.put ? need_scroll : scr_r;
      out_scrollback_lines <= HIST_OUT_W'(hist_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign sts.op          = op_r;
  assign sts.need_scroll = need_scroll;
  assign sts.sweep_done  = sweep_done;
  assign sts.out_free    = out_free;

  `TCW_ASSERT_IMP(a_col_in_range, 1'b1, CX_W'(col_r) < CX_W'(COLUMNS))
  `TCW_ASSERT_IMP(a_hist_saturates, 1'b1, hist_r <= HW'(HISTORY_DEPTH))
  `TCW_ASSERT_NXT(a_out_held, out_valid_r && !out_ready, out_valid_r)

endmodule

// File: hdl/text_console_writer.sv
// Put without scroll: captured, then result loaded; read adds a registered store read.
// Scroll: one store cell moved or blanked per cycle.
// Clear: one cell blanked per cycle.
// One word in flight: the next is taken once the result register is loaded.
// Reset: synchronous, active low; a clearing pass fills all COLUMNS*ROWS store cells
// (2000 by default) with 0x0F20 while in_ready stays low.
// ---------------------------------------------------------------------------
// Text console writer
// Text-mode console: put character, clear screen and read cell over a
// valid/ready channel, with scroll and a saturating scrolled-line count.
// ---------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS       = 80,
  parameter int ROWS          = 25,
  parameter int HISTORY_DEPTH = 100,
  parameter int TAB_WIDTH     = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tcw_pkg::OP_W-1:0]        in_operation,
  input  logic [tcw_pkg::CHAR_W-1:0]      in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]       in_cell_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcw_pkg::CELL_W-1:0]      out_read_data,
  output logic [tcw_pkg::COL_OUT_W-1:0]   out_cursor_col,
  output logic [tcw_pkg::ROW_OUT_W-1:0]   out_cursor_row,
  output logic                            out_scrolled,
  output logic [tcw_pkg::HIST_OUT_W-1:0]  out_scrollback_lines,
  input  logic                            cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]      cfg_wdata
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_dpath #(
    .COLUMNS       (COLUMNS),
    .ROWS          (ROWS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TAB_WIDTH     (TAB_WIDTH)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_operation         (in_operation),
    .in_char_code         (in_char_code),
    .in_cell_index        (in_cell_index),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_read_data        (out_read_data),
    .out_cursor_col       (out_cursor_col),
    .out_cursor_row       (out_cursor_row),
    .out_scrolled         (out_scrolled),
    .out_scrollback_lines (out_scrollback_lines),
    .cmd                  (cmd),
    .sts                  (sts)
  );

endmodule

// File: test/tb.sv
// ---------------------------------------------------------------------------
// Text console writer testbench
// Drives put, clear, read and unused operation words into the console over
// valid/ready, tracks screen, cursor and scrolled-line count in a local
// model, and checks every result word against it. Covers control
// characters, line and tab wrap, scroll on the last row, saturation of the
// count, and several attribute settings with random idling on both sides.
// ---------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam int COLS        = 80;
  localparam int ROWS        = 25;
  localparam int HIST_DEPTH  = 100;
  localparam int TAB_W       = 4;
  localparam int CELLS       = COLS * ROWS;
  localparam int CYCLE_LIMIT = 10000000;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [CELL_W-1:0]     data;
    logic [COL_OUT_W-1:0]  col;
    logic [ROW_OUT_W-1:0]  row;
    logic                  scrolled;
    logic [HIST_OUT_W-1:0] lines;
  } cell_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [OP_W-1:0]        in_operation = '0;
  logic [CHAR_W-1:0]      in_char_code = '0;
  logic [IDX_W-1:0]       in_cell_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CELL_W-1:0]      out_read_data;
  logic [COL_OUT_W-1:0]   out_cursor_col;
  logic [ROW_OUT_W-1:0]   out_cursor_row;
  logic                   out_scrolled;
  logic [HIST_OUT_W-1:0]  out_scrollback_lines;
  logic                   cfg_we = 1'b0;
  logic [ATTR_W-1:0]      cfg_wdata = '0;

  // console model
  logic [CELL_W-1:0] screen_model [CELLS];
  int                cur_col;
  int                cur_row;
  int                lines_off;
  logic [ATTR_W-1:0] attr_now;

  cell_report_t pending_resp [$];
  bit           valid_held = 1'b0;
  bit           gapless = 1'b0;
  int           rx_stall = 0;
  int           cycle_count = 0;
  int           faults = 0;
  int           words_sent = 0;
  int           results_checked = 0;
  int           scrolls_seen = 0;
  int           clears_seen = 0;
  int           attr_writes = 0;

  text_console_writer #(
    .COLUMNS(COLS), .ROWS(ROWS), .HISTORY_DEPTH(HIST_DEPTH), .TAB_WIDTH(TAB_W)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_char_code(in_char_code),
    .in_cell_index(in_cell_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_data(out_read_data), .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row), .out_scrolled(out_scrolled),
    .out_scrollback_lines(out_scrollback_lines),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Advance the console model by one word and return the result it gives.
  function automatic cell_report_t apply_word(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                              logic [IDX_W-1:0] idx);
    cell_report_t r;
    int i;
    r = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_NL) begin
          cur_col = 0;
          cur_row++;
        end else if (ch == CH_BS) begin
          if (cur_col > 0) begin
            cur_col--;
            screen_model[cur_row * COLS + cur_col] = {attr_now, CH_BLANK};
          end
        end else if (ch == CH_TAB) begin
          cur_col = (cur_col / TAB_W + 1) * TAB_W;
        end else begin
          screen_model[cur_row * COLS + cur_col] = {attr_now, ch};
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          if (lines_off < HIST_DEPTH) lines_off++;
          for (i = 0; i < (ROWS - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
          for (i = (ROWS - 1) * COLS; i < CELLS; i++) screen_model[i] = {attr_now, CH_BLANK};
          cur_row = ROWS - 1;
          r.scrolled = 1'b1;
          scrolls_seen++;
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_model[i] = {attr_now, CH_BLANK};
        cur_col = 0;
        cur_row = 0;
        lines_off = 0;
        clears_seen++;
      end
      OP_READ: begin
        if (idx < CELLS) r.data = screen_model[idx];
      end
      default: ;
    endcase
    r.col   = COL_OUT_W'(cur_col);
    r.row   = ROW_OUT_W'(cur_row);
    r.lines = HIST_OUT_W'(lines_off);
    return r;
  endfunction

  function automatic void log_fault(string why, cell_report_t want, cell_report_t got);
    faults++;
    if (faults <= 10) begin
      $display("[%0d] %s: expected data=%h col=%0d row=%0d scr=%0d lines=%0d",
               cycle_count, why, want.data, want.col, want.row, want.scrolled, want.lines);
      $display("      got data=%h col=%0d row=%0d scr=%0d lines=%0d",
               got.data, got.col, got.row, got.scrolled, got.lines);
    end
  endfunction

  // Result side: check each word taken, then draw the stall before the next one.
  always @(posedge clk) begin
    cell_report_t got;
    cell_report_t want;
    int n;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall  <= 0;
    end else if (out_valid && out_ready) begin
      got = '{out_read_data, out_cursor_col, out_cursor_row, out_scrolled,
              out_scrollback_lines};
      if (pending_resp.size() == 0) begin
        log_fault("result with nothing pending", '0, got);
      end else begin
        want = pending_resp.pop_front();
        results_checked++;
        if (got !== want) log_fault("result mismatch", want, got);
      end
      n = gapless ? 0 : $urandom_range(0, 7);
      rx_stall  <= n;
      out_ready <= (n == 0);
    end else if (rx_stall != 0) begin
      rx_stall  <= rx_stall - 1;
      out_ready <= (rx_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Valid stays high after a word is taken, so a back-to-back word can follow
  // without dropping it; release_input lowers it before any other wait.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      if (valid_held) in_valid <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_char_code  <= ch;
    in_cell_index <= idx;
    valid_held = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_resp.push_back(apply_word(op, ch, idx));
    words_sent++;
  endtask

  task automatic release_input();
    if (valid_held) in_valid <= 1'b0;
    valid_held = 1'b0;
  endtask

  // Wait for every pending result, then keep waiting so the console is idle.
  task automatic settle();
    release_input();
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [ATTR_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    attr_now = v;
    attr_writes++;
  endtask

  function automatic logic [CHAR_W-1:0] pick_glyph();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255)); while (c == CH_NL || c == CH_BS || c == CH_TAB);
    return c;
  endfunction

  // About half cells around the cursor, where the writes land; the rest any cell or index.
  function automatic logic [IDX_W-1:0] nearby_cell();
    case ($urandom_range(0, 3))
      0: return IDX_W'(cur_row * COLS + $urandom_range(0, COLS - 1));
      1: return IDX_W'(cur_row * COLS + (cur_col > 0 ? cur_col - 1 : 0));
      2: return IDX_W'($urandom_range(0, CELLS - 1));
      default: return IDX_W'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic fill_line();
    do send_word(OP_PUT, pick_glyph(), '0); while (cur_col != 0);
  endtask

  task automatic tab_run();
    do send_word(OP_PUT, CH_TAB, '0); while (cur_col != 0);
  endtask

  task automatic random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)      send_word(OP_PUT, pick_glyph(), IDX_W'($urandom_range(0, 2047)));
    else if (r < 62) send_word(OP_PUT, CH_NL, '0);
    else if (r < 67) send_word(OP_PUT, CH_BS, '0);
    else if (r < 72) send_word(OP_PUT, CH_TAB, '0);
    else if (r < 92) send_word(OP_READ, CHAR_W'($urandom_range(0, 255)), nearby_cell());
    else if (r < 94) send_word(OP_CLEAR, '0, '0);
    else if (r < 96) send_word(OP_UNUSED, CHAR_W'($urandom_range(0, 255)), nearby_cell());
    else send_word(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                   IDX_W'($urandom_range(0, 2047)));
  endtask

  task automatic test_directed();
    send_word(OP_PUT, 8'h00, '0);
    send_word(OP_PUT, 8'hFF, '0);
    send_word(OP_PUT, 8'h80, '0);
    send_word(OP_PUT, 8'h7F, '0);
    for (int i = 0; i < 4; i++) send_word(OP_READ, '0, IDX_W'(i));
    send_word(OP_PUT, CH_BS, '0);
    send_word(OP_READ, '0, 11'd3);
    send_word(OP_PUT, CH_TAB, '0);
    send_word(OP_PUT, CH_TAB, '0);
    send_word(OP_PUT, CH_NL, '0);
    // backspace at column zero: no change
    send_word(OP_PUT, CH_BS, '0);
    send_word(OP_READ, '0, 11'd1999);
    send_word(OP_READ, '0, 11'd2000);
    send_word(OP_READ, 8'hFF, 11'd2047);
    send_word(OP_UNUSED, CH_NL, 11'd5);
    send_word(OP_CLEAR, '0, '0);
    send_word(OP_READ, '0, '0);
    settle();
  endtask

  task automatic test_attribute();
    set_attribute(8'h00);
    send_word(OP_PUT, 8'h41, '0);
    send_word(OP_READ, '0, '0);
    set_attribute(8'hFF);
    send_word(OP_PUT, 8'hFF, '0);
    send_word(OP_READ, '0, 11'd1);
    send_word(OP_CLEAR, '0, '0);
    send_word(OP_READ, '0, 11'd1999);
    set_attribute(ATTR_RESET);
  endtask

  task automatic test_wrap_and_tab();
    gapless = 1'b0;
    send_word(OP_CLEAR, '0, '0);
    fill_line();
    for (int i = 0; i < 10; i++) send_word(OP_READ, '0, IDX_W'($urandom_range(0, COLS - 1)));
    send_word(OP_PUT, pick_glyph(), '0);
    tab_run();
    send_word(OP_PUT, CH_BS, '0);
    send_word(OP_PUT, CH_NL, '0);
    gapless = 1'b1;
    repeat ($urandom_range(1, 5)) send_word(OP_PUT, pick_glyph(), '0);
    while (cur_col != 0) send_word(OP_PUT, CH_BS, '0);
    send_word(OP_PUT, CH_BS, '0);
    send_word(OP_PUT, CH_NL, '0);
    settle();
  endtask

  // Run the cursor to the last row and keep scrolling well past the count limit.
  task automatic test_scroll_saturation();
    int start;
    int r;
    gapless = 1'b0;
    set_attribute(ATTR_W'($urandom_range(0, 255)));
    send_word(OP_CLEAR, '0, '0);
    start = scrolls_seen;
    while (scrolls_seen - start < HIST_DEPTH + 6) begin
      r = $urandom_range(0, 99);
      gapless = (scrolls_seen - start) % 20 >= 15;
      if (r < 60)      send_word(OP_PUT, CH_NL, '0);
      else if (r < 85) send_word(OP_PUT, pick_glyph(), '0);
      else if (r < 92) send_word(OP_PUT, CH_BS, '0);
      else if (r < 96) send_word(OP_PUT, CH_TAB, '0);
      else             send_word(OP_READ, '0, nearby_cell());
    end
    // wrap and tab off the last row with the count saturated
    fill_line();
    send_word(OP_READ, '0, IDX_W'((ROWS - 2) * COLS + $urandom_range(0, COLS - 1)));
    tab_run();
    send_word(OP_READ, '0, IDX_W'((ROWS - 1) * COLS));
    settle();
    gapless = 1'b0;
  endtask

  task automatic test_random();
    logic [ATTR_W-1:0] attrs [6];
    attrs = '{8'hA5, 8'hFF, 8'h00, 8'h5A, 8'h3C, ATTR_RESET};
    for (int phase = 0; phase < 6; phase++) begin
      set_attribute(phase % 2 == 0 ? ATTR_W'($urandom_range(0, 255)) : attrs[phase]);
      gapless = (phase == 2 || phase == 4);
      repeat (80) random_word();
    end
    gapless = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) screen_model[i] = CELL_RESET;
    cur_col   = 0;
    cur_row   = 0;
    lines_off = 0;
    attr_now  = ATTR_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_attribute();
    test_wrap_and_tab();
    test_scroll_saturation();
    test_random();
    settle();
    repeat (16) @(posedge clk);
    $display("Covered %0d words and %0d results: %0d scrolls, %0d clears, %0d attribute writes.",
             words_sent, results_checked, scrolls_seen, clears_seen, attr_writes);
    $display("Mismatches: %0d", faults);
    if (faults == 0 && pending_resp.size() == 0) begin
      $display("text_console_writer verification clean");
    end else begin
      $display("text_console_writer verification failed");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results pending", cycle_count,
             pending_resp.size());
    $display("text_console_writer verification failed");
    $finish;
  end

endmodule
